// ----- hdl/mrd_pkg.sv -----
`default_nettype none
package mrd_pkg;

   localparam int TOPIC_CAP_DEF     = 128;
   localparam int PAYLOAD_CAP_DEF   = 256;
   localparam int MAX_LEN_BYTES_DEF = 4;

   localparam int BYTES_LEFT_W = 28;
   localparam int TOPIC_LEN_W  = 16;

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_CONNACK_OK = 3'd1,
      EV_PINGRESP   = 3'd2,
      EV_PUBLISH    = 3'd3,
      EV_SUBACK     = 3'd4,
      EV_MALFORMED  = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      ROLE_NONE    = 2'd0,
      ROLE_TOPIC   = 2'd1,
      ROLE_PAYLOAD = 2'd2
   } role_type;

   localparam logic [3:0] KIND_CONNACK  = 4'h2;
   localparam logic [3:0] KIND_PUBLISH  = 4'h3;
   localparam logic [3:0] KIND_SUBACK   = 4'h9;
   localparam logic [3:0] KIND_PINGRESP = 4'hD;

endpackage
`default_nettype wire

// ----- hdl/mrd_req_if.sv -----
`default_nettype none
interface mrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/mrd_rsp_if.sv -----
`default_nettype none
interface mrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [1:0] data_role;
   logic [2:0] event_res;
   logic       packet_end;
   logic [6:0] kept_topic_len;
   logic [7:0] kept_payload_len;

   modport source (output valid, output data_byte, output data_role, output event_res,
                   output packet_end, output kept_topic_len, output kept_payload_len,
                   input ready);
   modport sink (input valid, input data_byte, input data_role, input event_res,
                 input packet_end, input kept_topic_len, input kept_payload_len,
                 output ready);
endinterface
`default_nettype wire

// ----- hdl/mqtt_receive_deframer_core.sv -----
`default_nettype none
// Each accepted byte gives its result transaction in the following cycle.
// One byte per cycle unless rsp stalls; the header/body state register updates
// in the same cycle the byte is accepted, and the result register frees on rsp ready.
// Reset (synchronous, active high): parser waits for a type byte, all counters clear,
// and no result is pending. No clearing pass is needed.
module mqtt_receive_deframer_core #(
   parameter int TOPIC_CAP     = mrd_pkg::TOPIC_CAP_DEF,
   parameter int PAYLOAD_CAP   = mrd_pkg::PAYLOAD_CAP_DEF,
   parameter int MAX_LEN_BYTES = mrd_pkg::MAX_LEN_BYTES_DEF
) (
   input  wire        clock,
   input  wire        reset,
   mrd_req_if.sink    req_chan,
   mrd_rsp_if.source  rsp_chan
);

   localparam int TK_W = $clog2(TOPIC_CAP);
   localparam int PK_W = $clog2(PAYLOAD_CAP);
   localparam int BL_W = mrd_pkg::BYTES_LEFT_W;
   localparam int TL_W = mrd_pkg::TOPIC_LEN_W;

   mrd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]       kind_ff, kind_in;
   logic [BL_W-1:0]  left_ff, left_in;
   logic [1:0]       shift_ff, shift_in;
   logic [1:0]       bidx_ff, bidx_in;
   logic             rc_ok_ff, rc_ok_in;
   logic [TL_W-1:0]  tlen_ff, tlen_in;
   logic [TL_W-1:0]  tleft_ff, tleft_in;
   logic             pvalid_ff, pvalid_in;
   logic [TK_W-1:0]  tkept_ff, tkept_in;
   logic [PK_W-1:0]  pkept_ff, pkept_in;

   logic             rsp_valid_ff;
   logic [7:0]       data_byte_ff, data_byte_in;
   logic [1:0]       data_role_ff;
   logic [2:0]       event_ff;
   logic             end_ff, end_in;
   logic [6:0]       ktl_ff, ktl_in;
   logic [7:0]       kpl_ff, kpl_in;

   mrd_pkg::role_type  role_in;
   mrd_pkg::event_type ev_in;

   logic             accept;
   logic [7:0]       b;
   logic [BL_W-1:0]  grp;
   logic [BL_W-1:0]  left_or;
   logic [BL_W-1:0]  left_dec;
   logic [TL_W-1:0]  tlen_new;
   logic [TK_W+6:0]  tk_ext;
   logic [PK_W+7:0]  pk_ext;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.rx_byte;

   always_comb begin
      unique case (shift_ff)
         2'd0: grp = {21'd0, b[6:0]};
         2'd1: grp = {14'd0, b[6:0], 7'd0};
         2'd2: grp = {7'd0, b[6:0], 14'd0};
         2'd3: grp = {b[6:0], 21'd0};
         default: grp = '0;
      endcase
   end

   assign left_or  = left_ff | grp;
   assign left_dec = (left_ff != '0) ? left_ff - BL_W'(1) : '0;
   assign tlen_new = {tlen_ff[TL_W-1:8], b};

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      left_in   = left_ff;
      shift_in  = shift_ff;
      bidx_in   = bidx_ff;
      rc_ok_in  = rc_ok_ff;
      tlen_in   = tlen_ff;
      tleft_in  = tleft_ff;
      pvalid_in = pvalid_ff;
      tkept_in  = tkept_ff;
      pkept_in  = pkept_ff;
      role_in   = mrd_pkg::ROLE_NONE;
      ev_in     = mrd_pkg::EV_NONE;
      end_in    = 1'b0;

      unique case (phase_ff)
         mrd_pkg::PH_LEN: begin
            left_in = left_or;
            if (b[7]) begin
               shift_in = shift_ff + 2'd1;
               if ({1'b0, shift_ff} + 3'd1 >= 3'(MAX_LEN_BYTES)) begin
                  ev_in    = mrd_pkg::EV_MALFORMED;
                  end_in   = 1'b1;
                  phase_in = mrd_pkg::PH_TYPE;
               end
            end else begin
               bidx_in   = '0;
               rc_ok_in  = 1'b0;
               tlen_in   = '0;
               tleft_in  = '0;
               pvalid_in = 1'b0;
               tkept_in  = '0;
               pkept_in  = '0;
               if (left_or == '0) begin
                  end_in   = 1'b1;
                  phase_in = mrd_pkg::PH_TYPE;
                  if (kind_ff == mrd_pkg::KIND_PINGRESP) ev_in = mrd_pkg::EV_PINGRESP;
               end else begin
                  phase_in = mrd_pkg::PH_BODY;
               end
            end
         end
         mrd_pkg::PH_BODY: begin
            if (bidx_ff != 2'd3) bidx_in = bidx_ff + 2'd1;
            left_in = left_dec;
            if (kind_ff == mrd_pkg::KIND_CONNACK) begin
               if (bidx_ff == 2'd1) rc_ok_in = (b == 8'd0);
            end else if (kind_ff == mrd_pkg::KIND_PUBLISH) begin
               if (bidx_ff == 2'd0) begin
                  tlen_in = {b, 8'd0};
               end else if (bidx_ff == 2'd1) begin
                  tlen_in   = tlen_new;
                  tleft_in  = tlen_new;
                  pvalid_in = (left_dec >= BL_W'(tlen_new));
               end else if (pvalid_ff) begin
                  if (tleft_ff != '0) begin
                     tleft_in = tleft_ff - TL_W'(1);
                     if (tkept_ff < TK_W'(TOPIC_CAP - 1)) begin
                        role_in  = mrd_pkg::ROLE_TOPIC;
                        tkept_in = tkept_ff + TK_W'(1);
                     end
                  end else if (pkept_ff < PK_W'(PAYLOAD_CAP - 1)) begin
                     role_in  = mrd_pkg::ROLE_PAYLOAD;
                     pkept_in = pkept_ff + PK_W'(1);
                  end
               end
            end
            if (left_dec == '0) begin
               end_in   = 1'b1;
               phase_in = mrd_pkg::PH_TYPE;
               priority if (kind_ff == mrd_pkg::KIND_CONNACK) begin
                  if (bidx_ff != 2'd0 && rc_ok_in) ev_in = mrd_pkg::EV_CONNACK_OK;
               end else if (kind_ff == mrd_pkg::KIND_PINGRESP) begin
                  ev_in = mrd_pkg::EV_PINGRESP;
               end else if (kind_ff == mrd_pkg::KIND_PUBLISH) begin
                  if (bidx_ff != 2'd0 && pvalid_in) ev_in = mrd_pkg::EV_PUBLISH;
               end else if (kind_ff == mrd_pkg::KIND_SUBACK) begin
                  ev_in = mrd_pkg::EV_SUBACK;
               end else begin
                  // other kinds: close the packet silently
                  ev_in = mrd_pkg::EV_NONE;
               end
            end
         end
         default: begin
            // type byte: flags nibble ignored
            kind_in  = b[7:4];
            left_in  = '0;
            shift_in = '0;
            phase_in = mrd_pkg::PH_LEN;
         end
      endcase
   end

   assign tk_ext       = {7'd0, tkept_in};
   assign pk_ext       = {8'd0, pkept_in};
   assign data_byte_in = (role_in != mrd_pkg::ROLE_NONE) ? b : 8'd0;
   assign ktl_in       = (ev_in == mrd_pkg::EV_PUBLISH) ? tk_ext[6:0] : 7'd0;
   assign kpl_in       = (ev_in == mrd_pkg::EV_PUBLISH) ? pk_ext[7:0] : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mrd_pkg::PH_TYPE;
         kind_ff   <= '0;
         left_ff   <= '0;
         shift_ff  <= '0;
         bidx_ff   <= '0;
         rc_ok_ff  <= 1'b0;
         tlen_ff   <= '0;
         tleft_ff  <= '0;
         pvalid_ff <= 1'b0;
         tkept_ff  <= '0;
         pkept_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         left_ff   <= left_in;
         shift_ff  <= shift_in;
         bidx_ff   <= bidx_in;
         rc_ok_ff  <= rc_ok_in;
         tlen_ff   <= tlen_in;
         tleft_ff  <= tleft_in;
         pvalid_ff <= pvalid_in;
         tkept_ff  <= tkept_in;
         pkept_ff  <= pkept_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the result payload until its transaction completes
   always_ff @(posedge clock) begin
      if (accept) begin
         data_byte_ff <= data_byte_in;
         data_role_ff <= role_in;
         event_ff     <= ev_in;
         end_ff       <= end_in;
         ktl_ff       <= ktl_in;
         kpl_ff       <= kpl_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.data_byte        = data_byte_ff;
   assign rsp_chan.data_role        = data_role_ff;
   assign rsp_chan.event_res        = event_ff;
   assign rsp_chan.packet_end       = end_ff;
   assign rsp_chan.kept_topic_len   = ktl_ff;
   assign rsp_chan.kept_payload_len = kpl_ff;

endmodule
`default_nettype wire

// ----- hdl/mrd_checker.sv -----
`default_nettype none
module mrd_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] data_byte,
   input wire [1:0] data_role,
   input wire [2:0] event_res,
   input wire       packet_end,
   input wire [6:0] kept_topic_len,
   input wire [7:0] kept_payload_len
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_res) && $stable(data_byte))
      else $error("result changed while stalled");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted byte produced no result");

   a_event_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_res != mrd_pkg::EV_NONE |-> packet_end)
      else $error("event without packet end");

   a_lens_only_publish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_res != mrd_pkg::EV_PUBLISH |->
         kept_topic_len == 7'd0 && kept_payload_len == 8'd0)
      else $error("kept lengths outside publish done");

   a_byte_only_with_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && data_role == mrd_pkg::ROLE_NONE |-> data_byte == 8'd0)
      else $error("data byte without role");

endmodule

bind mqtt_receive_deframer_core mrd_checker u_mrd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .data_byte        (rsp_chan.data_byte),
   .data_role        (rsp_chan.data_role),
   .event_res        (rsp_chan.event_res),
   .packet_end       (rsp_chan.packet_end),
   .kept_topic_len   (rsp_chan.kept_topic_len),
   .kept_payload_len (rsp_chan.kept_payload_len)
);
`default_nettype wire
